// ===== rtl/tcpcsm_pkg.sv =====
// Shared types and constants for the TCP connection state machine.
`timescale 1ns / 1ps
`default_nettype none

package tcpcsm_pkg;

  // TCP header flag bits
  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [7:0] FLAG_NONE = 8'h00;

  typedef enum logic [1:0] {
    EV_OPEN    = 2'd0,
    EV_RECEIVE = 2'd1,
    EV_CLOSE   = 2'd2
  } event_e;

  typedef enum logic [3:0] {
    ST_CLOSED      = 4'd0,
    ST_LISTEN      = 4'd1,
    ST_SYN_SENT    = 4'd2,
    ST_SYN_RCVD    = 4'd3,
    ST_ESTABLISHED = 4'd4,
    ST_FIN_WAIT1   = 4'd5,
    ST_FIN_WAIT2   = 4'd6,
    ST_CLOSE_WAIT  = 4'd7,
    ST_CLOSING     = 4'd8,
    ST_LAST_ACK    = 4'd9,
    ST_TIMEWAIT    = 4'd10
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/tcpcsm_if.sv =====
// Valid/ready channel interfaces for connection events and results.
`timescale 1ns / 1ps
`default_nettype none

interface tcpcsm_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] rx_flags;

  modport source (output valid, output event_kind, output rx_flags, input ready);
  modport sink   (input valid, input event_kind, input rx_flags, output ready);
endinterface

interface tcpcsm_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] next_state;
  logic       send_valid;
  logic [7:0] send_flags;
  logic       teardown;

  modport source (output valid, output next_state, output send_valid,
                  output send_flags, output teardown, input ready);
  modport sink   (input valid, input next_state, input send_valid,
                  input send_flags, input teardown, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcp_connection_state_machine_core.sv =====
// Top level: one TCP connection state machine with registered event and result stages.
//
//   channel | dir | payload                                        | handshake
//   evt_i   | in  | event_kind[1:0], rx_flags[7:0]                 | valid/ready
//   res_o   | out | next_state[3:0], send_valid, send_flags[7:0],   | valid/ready
//           |     | teardown                                       |
//
// One event per cycle sustained while res_o.ready stays high; an accepted event beat
// passes through the event register, then state decode into the result register.
// The connection state register is the only loop: it updates as each event moves
// into the result register.
// Reset puts the connection in CLOSED and empties both stages.
// A stalled result holds the event stage; evt_i.ready drops only when both stages
// are full and res_o.ready is low.
`timescale 1ns / 1ps
`default_nettype none

module tcp_connection_state_machine_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  tcpcsm_evt_if.sink          evt_i,
  tcpcsm_res_if.source        res_o
);

  // event stage
  logic       evt_vld_q;
  logic [1:0] evt_kind_q;
  logic [7:0] evt_flags_q;

  // result stage
  logic       res_vld_q;
  logic [3:0] res_state_q;
  logic [7:0] res_flags_q;
  logic       res_tdn_q;

  tcpcsm_pkg::state_e state_q, state_d;
  logic [7:0]         snd_flags;
  logic               tdn;
  logic               advance;
  logic               rx, cl, op;

  assign advance   = evt_vld_q && (!res_vld_q || res_o.ready);
  assign evt_i.ready = !evt_vld_q || advance;

  assign rx = (evt_kind_q == tcpcsm_pkg::EV_RECEIVE);
  assign cl = (evt_kind_q == tcpcsm_pkg::EV_CLOSE);
  assign op = (evt_kind_q == tcpcsm_pkg::EV_OPEN);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcpcsm_pkg::ST_CLOSED: begin
        if (op) state_d = tcpcsm_pkg::ST_LISTEN;
      end
      tcpcsm_pkg::ST_LISTEN: begin
        if (rx && evt_flags_q == tcpcsm_pkg::FLAG_SYN) state_d = tcpcsm_pkg::ST_SYN_RCVD;
      end
      tcpcsm_pkg::ST_SYN_SENT: begin
        if (rx && evt_flags_q == tcpcsm_pkg::FLAG_SYN) begin
          state_d = tcpcsm_pkg::ST_SYN_RCVD;
        end else if (rx && evt_flags_q == (tcpcsm_pkg::FLAG_SYN | tcpcsm_pkg::FLAG_ACK)) begin
          state_d = tcpcsm_pkg::ST_ESTABLISHED;
        end
      end
      tcpcsm_pkg::ST_SYN_RCVD: begin
        if (rx && evt_flags_q == tcpcsm_pkg::FLAG_RST) begin
          state_d = tcpcsm_pkg::ST_LISTEN;
        end else if (rx && evt_flags_q == tcpcsm_pkg::FLAG_ACK) begin
          state_d = tcpcsm_pkg::ST_ESTABLISHED;
        end else if (cl) begin
          state_d = tcpcsm_pkg::ST_FIN_WAIT1;
        end
      end
      tcpcsm_pkg::ST_ESTABLISHED: begin
        if (rx && evt_flags_q == tcpcsm_pkg::FLAG_FIN) begin
          state_d = tcpcsm_pkg::ST_CLOSE_WAIT;
        end else if (cl) begin
          state_d = tcpcsm_pkg::ST_FIN_WAIT1;
        end
      end
      tcpcsm_pkg::ST_FIN_WAIT1: begin
        if (rx && evt_flags_q == tcpcsm_pkg::FLAG_ACK) begin
          state_d = tcpcsm_pkg::ST_FIN_WAIT2;
        end else if (rx && evt_flags_q == tcpcsm_pkg::FLAG_FIN) begin
          state_d = tcpcsm_pkg::ST_CLOSING;
        end
      end
      tcpcsm_pkg::ST_FIN_WAIT2: begin
        if (rx && evt_flags_q == tcpcsm_pkg::FLAG_FIN) state_d = tcpcsm_pkg::ST_TIMEWAIT;
      end
      tcpcsm_pkg::ST_CLOSE_WAIT: begin
        if (cl) state_d = tcpcsm_pkg::ST_LAST_ACK;
      end
      tcpcsm_pkg::ST_CLOSING: begin
        if (rx && evt_flags_q == tcpcsm_pkg::FLAG_FIN) state_d = tcpcsm_pkg::ST_TIMEWAIT;
      end
      tcpcsm_pkg::ST_LAST_ACK: begin
        if (rx && evt_flags_q == tcpcsm_pkg::FLAG_ACK) state_d = tcpcsm_pkg::ST_CLOSED;
      end
      tcpcsm_pkg::ST_TIMEWAIT: begin
        state_d = tcpcsm_pkg::ST_CLOSED;  // any event ends the connection
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  // segment request and teardown
  always_comb begin
    snd_flags = tcpcsm_pkg::FLAG_NONE;
    tdn       = 1'b0;
    unique case (state_q)
      tcpcsm_pkg::ST_LISTEN: begin
        if (rx && evt_flags_q == tcpcsm_pkg::FLAG_SYN) begin
          snd_flags = tcpcsm_pkg::FLAG_SYN | tcpcsm_pkg::FLAG_ACK;
        end
      end
      tcpcsm_pkg::ST_SYN_SENT: begin
        if (rx && evt_flags_q == (tcpcsm_pkg::FLAG_SYN | tcpcsm_pkg::FLAG_ACK)) begin
          snd_flags = tcpcsm_pkg::FLAG_ACK;
        end
      end
      tcpcsm_pkg::ST_SYN_RCVD: begin
        if (cl) snd_flags = tcpcsm_pkg::FLAG_FIN;
      end
      tcpcsm_pkg::ST_ESTABLISHED: begin
        if (!(rx && evt_flags_q == tcpcsm_pkg::FLAG_FIN) && cl) snd_flags = tcpcsm_pkg::FLAG_FIN;
      end
      tcpcsm_pkg::ST_FIN_WAIT2: begin
        if (rx && evt_flags_q == tcpcsm_pkg::FLAG_FIN) snd_flags = tcpcsm_pkg::FLAG_ACK;
      end
      tcpcsm_pkg::ST_TIMEWAIT: begin
        tdn = 1'b1;
      end
      default: begin
        snd_flags = tcpcsm_pkg::FLAG_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
      state_q   <= tcpcsm_pkg::ST_CLOSED;
    end else begin
      if (evt_i.ready) evt_vld_q <= evt_i.valid;
      if (advance) begin
        res_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      evt_kind_q  <= evt_i.event_kind;
      evt_flags_q <= evt_i.rx_flags;
    end
    if (advance) begin
      res_state_q <= state_d;
      res_flags_q <= snd_flags;
      res_tdn_q   <= tdn;
    end
  end

  assign res_o.valid      = res_vld_q;
  assign res_o.next_state = res_state_q;
  assign res_o.send_valid = (res_flags_q != tcpcsm_pkg::FLAG_NONE);
  assign res_o.send_flags = res_flags_q;
  assign res_o.teardown   = res_tdn_q;

`ifndef ASSERT_OFF
  // the shown result always carries the current connection state
  a_res_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (res_o.next_state == state_q))
    else $error("result state differs from connection state");

  // teardown only on the way out of TIME-WAIT, into CLOSED
  a_teardown_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_tdn_q) |-> (res_state_q == tcpcsm_pkg::ST_CLOSED))
    else $error("teardown without CLOSED");

  a_timewait_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q == tcpcsm_pkg::ST_TIMEWAIT) |=> (res_tdn_q && res_vld_q))
    else $error("TIME-WAIT event did not tear down");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_tcp_connection_state_machine_core.sv =====
// Self-checking testbench: drives event beats, predicts each result beat and compares.
`timescale 1ns / 1ps

module tb_tcp_connection_state_machine_core;
  import tcpcsm_pkg::*;

  localparam int unsigned RANDOM_EVENTS = 1575;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned PRINT_CAP     = 40;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] flags;
  } conn_event_t;

  typedef struct packed {
    logic [3:0] state;
    logic       send;
    logic [7:0] flags;
    logic       teardown;
  } conn_result_t;

  logic clk_i;
  logic rst_ni;

  tcpcsm_evt_if conn_evt ();
  tcpcsm_res_if conn_res ();

  tcp_connection_state_machine_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (conn_evt),
    .res_o  (conn_res)
  );

  conn_event_t  pending_events[$];
  conn_result_t expected_results[$];

  logic [3:0]  conn_state;
  logic [3:0]  plan_state;
  int unsigned total_events;
  int unsigned events_accepted;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned segments_sent;
  int unsigned teardowns_seen;
  logic [15:0] states_seen;
  int unsigned idle_cycles;

  int unsigned src_wait;
  int unsigned src_mode;
  int unsigned src_launches;
  int unsigned snk_wait;
  int unsigned snk_mode;

  // Next state, outgoing segment and teardown for one event in a given state.
  function automatic conn_result_t step_connection(input logic [3:0] cur,
                                                   input conn_event_t ev);
    conn_result_t r;
    logic         rx;
    logic         cl;
    rx         = (ev.kind == EV_RECEIVE);
    cl         = (ev.kind == EV_CLOSE);
    r.state    = cur;
    r.flags    = FLAG_NONE;
    r.teardown = 1'b0;
    case (cur)
      ST_CLOSED: begin
        if (ev.kind == EV_OPEN) r.state = ST_LISTEN;
      end
      ST_LISTEN: begin
        if (rx && ev.flags == FLAG_SYN) begin
          r.state = ST_SYN_RCVD;
          r.flags = FLAG_SYN | FLAG_ACK;
        end
      end
      ST_SYN_SENT: begin
        if (rx && ev.flags == FLAG_SYN) begin
          r.state = ST_SYN_RCVD;
        end else if (rx && ev.flags == (FLAG_SYN | FLAG_ACK)) begin
          r.state = ST_ESTABLISHED;
          r.flags = FLAG_ACK;
        end
      end
      ST_SYN_RCVD: begin
        if (rx && ev.flags == FLAG_RST) begin
          r.state = ST_LISTEN;
        end else if (rx && ev.flags == FLAG_ACK) begin
          r.state = ST_ESTABLISHED;
        end else if (cl) begin
          r.state = ST_FIN_WAIT1;
          r.flags = FLAG_FIN;
        end
      end
      ST_ESTABLISHED: begin
        if (rx && ev.flags == FLAG_FIN) begin
          r.state = ST_CLOSE_WAIT;
        end else if (cl) begin
          r.state = ST_FIN_WAIT1;
          r.flags = FLAG_FIN;
        end
      end
      ST_FIN_WAIT1: begin
        if (rx && ev.flags == FLAG_ACK) r.state = ST_FIN_WAIT2;
        else if (rx && ev.flags == FLAG_FIN) r.state = ST_CLOSING;
      end
      ST_FIN_WAIT2: begin
        if (rx && ev.flags == FLAG_FIN) begin
          r.state = ST_TIMEWAIT;
          r.flags = FLAG_ACK;
        end
      end
      ST_CLOSE_WAIT: begin
        if (cl) r.state = ST_LAST_ACK;
      end
      ST_CLOSING: begin
        if (rx && ev.flags == FLAG_FIN) r.state = ST_TIMEWAIT;
      end
      ST_LAST_ACK: begin
        if (rx && ev.flags == FLAG_ACK) r.state = ST_CLOSED;
      end
      ST_TIMEWAIT: begin
        // any event, even an unused code, releases the connection
        r.state    = ST_CLOSED;
        r.teardown = 1'b1;
      end
      default: ;
    endcase
    r.send = (r.flags != FLAG_NONE);
    return r;
  endfunction

  // An event that moves the connection forward from the given state.
  function automatic conn_event_t pick_progress(input logic [3:0] st);
    conn_event_t e;
    e.kind  = EV_RECEIVE;
    e.flags = 8'($urandom_range(0, 255));
    case (st)
      ST_CLOSED:      e.kind = EV_OPEN;
      ST_LISTEN:      e.flags = FLAG_SYN;
      ST_SYN_RCVD: begin
        case ($urandom_range(0, 2))
          0:       e.flags = FLAG_RST;
          1:       e.flags = FLAG_ACK;
          default: e.kind = EV_CLOSE;
        endcase
      end
      ST_ESTABLISHED: begin
        if ($urandom_range(0, 1) == 0) e.flags = FLAG_FIN;
        else e.kind = EV_CLOSE;
      end
      ST_FIN_WAIT1:   e.flags = ($urandom_range(0, 1) == 0) ? FLAG_ACK : FLAG_FIN;
      ST_FIN_WAIT2:   e.flags = FLAG_FIN;
      ST_CLOSE_WAIT:  e.kind = EV_CLOSE;
      ST_CLOSING:     e.flags = FLAG_FIN;
      ST_LAST_ACK:    e.flags = FLAG_ACK;
      default:        e.kind = 2'($urandom_range(0, 3));
    endcase
    return e;
  endfunction

  // Idle cycles before the next beat; mode 0 gives back-to-back stretches.
  function automatic int unsigned draw_wait(input int unsigned mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
    return $urandom_range(0, 11);
  endfunction

  task automatic queue_event(input logic [1:0] kind, input logic [7:0] flags);
    conn_event_t  e;
    conn_result_t r;
    e.kind  = kind;
    e.flags = flags;
    pending_events.push_back(e);
    r          = step_connection(plan_state, e);
    plan_state = r.state;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Event source.
  always @(posedge clk_i or negedge rst_ni) begin : evt_driver
    conn_event_t  nxt;
    conn_result_t exp;
    if (!rst_ni) begin
      conn_evt.valid      <= 1'b0;
      conn_evt.event_kind <= EV_OPEN;
      conn_evt.rx_flags   <= FLAG_NONE;
      src_wait            <= 0;
      conn_state          <= ST_CLOSED;
    end else begin
      if (conn_evt.valid && conn_evt.ready) begin
        nxt.kind  = conn_evt.event_kind;
        nxt.flags = conn_evt.rx_flags;
        exp       = step_connection(conn_state, nxt);
        conn_state <= exp.state;
        expected_results.push_back(exp);
        events_accepted++;
      end
      if (!conn_evt.valid || conn_evt.ready) begin
        if (src_wait > 0) begin
          conn_evt.valid <= 1'b0;
          src_wait       <= src_wait - 1;
        end else if (pending_events.size() > 0) begin
          nxt = pending_events.pop_front();
          conn_evt.valid      <= 1'b1;
          conn_evt.event_kind <= nxt.kind;
          conn_evt.rx_flags   <= nxt.flags;
          if (src_launches % 64 == 0) src_mode = $urandom_range(0, 2);
          src_launches++;
          src_wait <= draw_wait(src_mode);
        end else begin
          conn_evt.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink and checker.
  always @(posedge clk_i or negedge rst_ni) begin : res_monitor
    conn_result_t exp;
    int unsigned  w;
    if (!rst_ni) begin
      conn_res.ready <= 1'b0;
      snk_wait       <= 0;
    end else begin
      w = snk_wait;
      if (conn_res.valid && conn_res.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result beat, next_state",
                          8'(conn_res.next_state), 8'h00);
        end else begin
          exp = expected_results.pop_front();
          if (conn_res.next_state !== exp.state)
            report_mismatch("next_state", 8'(conn_res.next_state), 8'(exp.state));
          if (conn_res.send_valid !== exp.send)
            report_mismatch("send_valid", 8'(conn_res.send_valid), 8'(exp.send));
          if (conn_res.send_flags !== exp.flags)
            report_mismatch("send_flags", conn_res.send_flags, exp.flags);
          if (conn_res.teardown !== exp.teardown)
            report_mismatch("teardown", 8'(conn_res.teardown), 8'(exp.teardown));
          states_seen[exp.state] = 1'b1;
          if (exp.send) segments_sent++;
          if (exp.teardown) teardowns_seen++;
        end
        results_checked++;
        if (results_checked % 64 == 0) snk_mode = $urandom_range(0, 2);
        w = draw_wait(snk_mode);
      end
      if (w > 0) begin
        conn_res.ready <= 1'b0;
        snk_wait       <= w - 1;
      end else begin
        conn_res.ready <= 1'b1;
        snk_wait       <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((conn_evt.valid && conn_evt.ready) || (conn_res.valid && conn_res.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    conn_event_t  e;
    int unsigned  pick;
    rst_ni              = 1'b0;
    conn_evt.valid      = 1'b0;
    conn_evt.event_kind = EV_OPEN;
    conn_evt.rx_flags   = FLAG_NONE;
    conn_res.ready      = 1'b0;
    events_accepted     = 0;
    results_checked     = 0;
    mismatches          = 0;
    segments_sent       = 0;
    teardowns_seen      = 0;
    states_seen         = '0;
    idle_cycles         = 0;
    src_mode            = 0;
    src_launches        = 0;
    snk_mode            = 0;
    plan_state          = ST_CLOSED;

    // Directed: full handshake, active close through FIN-WAIT-2 and TIME-WAIT,
    // unmatched events with extreme flags, unused event code.
    queue_event(2'd3, 8'hFF);             // unused code in CLOSED: kept
    queue_event(EV_CLOSE, 8'hFF);         // close in CLOSED: kept
    queue_event(EV_OPEN, 8'hFF);          // flags ignored on open
    queue_event(EV_RECEIVE, 8'hFF);       // near-miss SYN
    queue_event(EV_RECEIVE, FLAG_SYN);
    queue_event(EV_RECEIVE, FLAG_ACK | FLAG_SYN);
    queue_event(EV_RECEIVE, FLAG_ACK);
    queue_event(EV_CLOSE, 8'h00);
    queue_event(EV_RECEIVE, FLAG_ACK);
    queue_event(EV_RECEIVE, FLAG_FIN);
    queue_event(2'd3, 8'h00);             // TIME-WAIT ends on any code
    // reset from SYN-RECEIVED, then simultaneous close through CLOSING
    queue_event(EV_OPEN, 8'h00);
    queue_event(EV_RECEIVE, FLAG_SYN);
    queue_event(EV_RECEIVE, FLAG_RST);
    queue_event(EV_RECEIVE, FLAG_SYN);
    queue_event(EV_CLOSE, 8'hAA);
    queue_event(EV_RECEIVE, FLAG_FIN);
    queue_event(EV_RECEIVE, FLAG_FIN);
    queue_event(EV_CLOSE, 8'h55);
    // passive close
    queue_event(EV_OPEN, 8'h00);
    queue_event(EV_RECEIVE, FLAG_SYN);
    queue_event(EV_RECEIVE, FLAG_ACK);
    queue_event(EV_RECEIVE, FLAG_FIN);
    queue_event(EV_CLOSE, 8'h00);
    queue_event(EV_RECEIVE, FLAG_ACK);

    // Random: mostly forward-moving events, the rest near misses and noise.
    repeat (RANDOM_EVENTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        e = pick_progress(plan_state);
      end else if (pick < 88) begin
        e       = pick_progress(plan_state);
        e.kind  = EV_RECEIVE;
        e.flags = e.flags ^ (8'h01 << $urandom_range(0, 7));
      end else begin
        e.kind  = 2'($urandom_range(0, 3));
        e.flags = 8'($urandom_range(0, 255));
      end
      queue_event(e.kind, e.flags);
    end
    total_events = pending_events.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (events_accepted < total_events) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d events; %0d result beats checked, %0d mismatches.",
             total_events, results_checked, mismatches);
    $display("Outgoing segments %0d, teardowns %0d, %0d distinct states reached.",
             segments_sent, teardowns_seen, $countones(states_seen));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
